>>> sv/fmlfo_pkg.sv
// Shared constants, types and helper functions of the FM LFO block.
package fmlfo_pkg;

   localparam int CHANNELS       = 8;
   localparam int CH_W           = 3;
   localparam int IDX_W          = 9;
   localparam int TABLE_SIZE     = 512;
   localparam int TIME_PRECISION = 4096;
   localparam int PM_SCALE_SHIFT = 12;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 64;

   localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

   // item opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_STOP  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // waveform shapes
   localparam logic [1:0] SHAPE_SAW    = 2'd0;
   localparam logic [1:0] SHAPE_SQUARE = 2'd1;
   localparam logic [1:0] SHAPE_TRI    = 2'd2;
   localparam logic [1:0] SHAPE_NOISE  = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LFO_RATE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PM_DEPTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AM_DEPTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SHAPE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CHAN_SENS = 3'd5;

   typedef struct packed {
      logic            accept;   // capture the request transaction
      logic            step;     // apply opcode to oscillator state
      logic            wave;     // derive wave values from phase index
      logic            mul;      // form products for mul_ch
      logic [CH_W-1:0] mul_ch;
      logic            emit;     // load result register for ch
      logic [CH_W-1:0] ch;
   } cmd_type;

   // PM multiplier is 0 or a power of two: return its log2
   function automatic logic [2:0] pms_mult_shift(input logic [2:0] pms);
      logic [2:0] r;
      case (pms)
         3'd2:    r = 3'd1;
         3'd3:    r = 3'd2;
         3'd4:    r = 3'd3;
         3'd5:    r = 3'd4;
         3'd6:    r = 3'd5;
         3'd7:    r = 3'd5;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] pms_lshift(input logic [2:0] pms);
      logic [1:0] r;
      case (pms)
         3'd6:    r = 2'd1;
         3'd7:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

>>> sv/fmlfo_ctrl.sv
// Sequencer of the FM LFO: item intake, state update and channel loop.
module fmlfo_ctrl import fmlfo_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_STEP = 3'd1;
   localparam logic [2:0] S_WAVE = 3'd2;
   localparam logic [2:0] S_MUL0 = 3'd3;
   localparam logic [2:0] S_CHAN = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;
   logic            emit;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (state_ff == S_CHAN) && out_free;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.accept = req_valid && (state_ff == S_IDLE);
      cmd.step   = (state_ff == S_STEP);
      cmd.wave   = (state_ff == S_WAVE);
      cmd.emit   = emit;
      cmd.ch     = ch_ff;
      // products for the next channel are formed while this one is loaded
      cmd.mul    = (state_ff == S_MUL0) || emit;
      cmd.mul_ch = (state_ff == S_MUL0) ? '0 : ch_ff + CH_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_STEP;
         end
         S_STEP: state_in = S_WAVE;
         S_WAVE: state_in = S_MUL0;
         S_MUL0: begin
            ch_in    = '0;
            state_in = S_CHAN;
         end
         S_CHAN: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               ch_in        = ch_ff + CH_W'(1);
               if (ch_ff == LAST_CH) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_step: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_STEP))
      else $error("accepted transaction did not start the state update");

   a_loop_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL0) |=> (ch_ff == '0 && state_ff == S_CHAN))
      else $error("channel loop did not start at channel zero");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (emit && ch_ff == LAST_CH) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("last channel did not close the item");

   a_stall_holds_channel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHAN && rsp_valid_ff && rsp_stall) |=> $stable(ch_ff))
      else $error("channel advanced while result register was stalled");

endmodule

>>> sv/fmlfo_dp.sv
// Datapath of the FM LFO: registers, oscillator state, waves and scaling.
module fmlfo_dp import fmlfo_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [1:0]            req_opcode,
   input  logic [IDX_W-1:0]      req_noise_index,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output logic [CH_W-1:0]       rsp_channel,
   output logic signed [9:0]     rsp_pm_value,
   output logic [9:0]            rsp_am_value,
   output logic                  rsp_last
);

   // configuration
   logic [19:0] time_step_ff;
   logic [7:0]  rate_ff;
   logic [6:0]  pm_depth_ff;
   logic [6:0]  am_depth_ff;
   logic [1:0]  shape_ff;
   logic [63:0] sens_ff;

   // captured transaction
   logic [1:0]       op_ff;
   logic [IDX_W-1:0] noise_ff;

   // oscillator state
   logic [31:0]      acc_ff, acc_in;
   logic [3:0]       sub_ff, sub_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             running_ff, running_in;

   // wave values
   logic [7:0] pm_mag_ff, pm_mag_in;
   logic       pm_neg_ff, pm_neg_in;
   logic [8:0] am_ff, am_in;

   // per-channel products
   logic [14:0] pm_prod_ff;
   logic [2:0]  pms_ff;
   logic [15:0] am_prod_ff;
   logic [1:0]  ams_ff;

   // output register
   logic [CH_W-1:0]   out_ch_ff;
   logic signed [9:0] out_pm_ff;
   logic [9:0]        out_am_ff;
   logic              out_last_ff;

   // step arithmetic
   logic [3:0]  shift_raw, shift_eff;
   logic [5:0]  step;
   logic [31:0] limit;
   logic [31:0] acc_sum;
   logic        ovf;
   logic [6:0]  sub_sum;
   logic [2:0]  adv;

   // channel arithmetic
   logic [7:0]  sens_byte;
   logic [19:0] pm_scaled;
   logic [9:0]  pmag;
   logic [9:0]  amv;

   always_comb begin
      shift_raw = 4'd15 - rate_ff[7:4];
      shift_eff = (shift_raw == 4'd0) ? 4'd1 : shift_raw;
      step      = (shift_raw == 4'd0) ? {5'd16 + {1'b0, rate_ff[3:0]}, 1'b0}
                                      : {1'b0, 5'd16 + {1'b0, rate_ff[3:0]}};
      limit     = (32'd8 << shift_eff) * 32'(TIME_PRECISION);
      acc_sum   = acc_ff + {12'd0, time_step_ff};
      ovf       = (acc_sum >= limit);
      sub_sum   = {3'd0, sub_ff} + {1'b0, step};
      adv       = sub_sum[6:4];
   end

   always_comb begin
      acc_in     = acc_ff;
      sub_in     = sub_ff;
      idx_in     = idx_ff;
      running_in = running_ff;
      if (cmd.step) begin
         case (op_ff)
            OP_TICK: begin
               if (running_ff) begin
                  if (ovf) begin
                     acc_in = '0;
                     sub_in = sub_sum[3:0];
                     case (shape_ff)
                        SHAPE_TRI:   idx_in = idx_ff + {5'd0, adv, 1'b0};
                        SHAPE_NOISE: idx_in = noise_ff;
                        default:     idx_in = idx_ff + {6'd0, adv};
                     endcase
                  end else begin
                     acc_in = acc_sum;
                  end
               end
            end
            OP_STOP: begin
               running_in = 1'b0;
               idx_in     = '0;
            end
            OP_START: running_in = 1'b1;
            default: ;
         endcase
      end
      // a rate write restarts the period
      if (csr_write_enable && csr_index == REG_LFO_RATE) acc_in = '0;
   end

   always_comb begin
      pm_mag_in = pm_mag_ff;
      pm_neg_in = pm_neg_ff;
      am_in     = am_ff;
      case (shape_ff)
         SHAPE_SQUARE: begin
            pm_mag_in = 8'd128;
            pm_neg_in = idx_ff[7];
            am_in     = idx_ff[7] ? 9'd0 : 9'd256;
         end
         SHAPE_TRI: begin
            case (idx_ff[8:7])
               2'd0: begin
                  pm_mag_in = idx_ff[7:0];
                  pm_neg_in = 1'b0;
               end
               2'd1: begin
                  pm_mag_in = 8'(9'd255 - idx_ff);
                  pm_neg_in = 1'b0;
               end
               2'd2: begin
                  pm_mag_in = 8'(idx_ff - 9'd256);
                  pm_neg_in = 1'b1;
               end
               default: begin
                  pm_mag_in = 8'(9'd511 - idx_ff);
                  pm_neg_in = 1'b1;
               end
            endcase
            am_in = idx_ff[8] ? {1'b0, idx_ff[7:0]} : {1'b0, 8'd255 - idx_ff[7:0]};
         end
         default: begin
            pm_mag_in = idx_ff[7] ? 8'd255 - idx_ff[7:0] : idx_ff[7:0];
            pm_neg_in = idx_ff[7];
            am_in     = {1'b0, 8'd255 - idx_ff[7:0]};
         end
      endcase
   end

   always_comb begin
      sens_byte = sens_ff[{cmd.mul_ch, 3'b000} +: 8];
      pm_scaled = {5'd0, pm_prod_ff} << pms_mult_shift(pms_ff);
      pmag      = (pms_ff == 3'd0) ? 10'd0
                                   : {2'd0, pm_scaled[PM_SCALE_SHIFT +: 8]} << pms_lshift(pms_ff);
      amv       = (ams_ff == 2'd0) ? 10'd0
                                   : {1'b0, am_prod_ff[15:7]} << (ams_ff - 2'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= 20'd4096;
         rate_ff      <= '0;
         pm_depth_ff  <= '0;
         am_depth_ff  <= '0;
         shape_ff     <= SHAPE_SAW;
         sens_ff      <= '0;
         acc_ff       <= '0;
         sub_ff       <= '0;
         idx_ff       <= '0;
         running_ff   <= 1'b1;
      end else begin
         acc_ff     <= acc_in;
         sub_ff     <= sub_in;
         idx_ff     <= idx_in;
         running_ff <= running_in;
         if (csr_write_enable) begin
            case (csr_index)
               REG_TIME_STEP: time_step_ff <= csr_write_data[19:0];
               REG_LFO_RATE:  rate_ff      <= csr_write_data[7:0];
               REG_PM_DEPTH:  pm_depth_ff  <= csr_write_data[6:0];
               REG_AM_DEPTH:  am_depth_ff  <= csr_write_data[6:0];
               REG_SHAPE:     shape_ff     <= csr_write_data[1:0];
               REG_CHAN_SENS: sens_ff      <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_opcode;
         noise_ff <= req_noise_index;
      end
      if (cmd.wave) begin
         pm_mag_ff <= pm_mag_in;
         pm_neg_ff <= pm_neg_in;
         am_ff     <= am_in;
      end
      if (cmd.mul) begin
         pm_prod_ff <= pm_mag_ff * pm_depth_ff;
         pms_ff     <= sens_byte[6:4];
         am_prod_ff <= am_ff * am_depth_ff;
         ams_ff     <= sens_byte[1:0];
      end
      if (cmd.emit) begin
         out_ch_ff   <= cmd.ch;
         out_pm_ff   <= pm_neg_ff ? -signed'(pmag) : signed'(pmag);
         out_am_ff   <= amv;
         out_last_ff <= (cmd.ch == LAST_CH);
      end
   end

   assign rsp_channel  = out_ch_ff;
   assign rsp_pm_value = out_pm_ff;
   assign rsp_am_value = out_am_ff;
   assign rsp_last     = out_last_ff;

endmodule

>>> sv/fm_lfo_pm_am_generator_top.sv
// FM synth LFO top level: per-channel PM and AM values from a shared oscillator.
//
// Request channel (req_valid / req_stall): one transaction carries an opcode
// (sample tick, stop with phase reset, start) and a noise phase index used by
// the noise shape when the oscillator period elapses.
// Response channel (rsp_valid / rsp_stall): every request yields one
// transaction per channel, channel 0 first; rsp_last marks the final one.
// Configuration: csr_write_enable with csr_index and csr_write_data writes one
// register per cycle; write only while no request is in flight.
// Timing: a request is taken in the idle state, then the oscillator is
// updated (S_STEP), the wave value is derived (S_WAVE), channel 0 products are
// formed (S_MUL0), and the channel loop loads one result per cycle through the
// shared multiplier pair while the receiver does not stall; req_stall is high
// from the update until the final result is loaded.
// When the receiver stalls, the result register holds and the channel loop
// waits; a new request is taken while the final result still waits.
// Reset (synchronous) restores register defaults, clears the oscillator and
// leaves it running; no clearing pass is needed.
module fm_lfo_pm_am_generator_top import fmlfo_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_opcode,
   input  logic [IDX_W-1:0]      req_noise_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CH_W-1:0]       rsp_channel,
   output logic signed [9:0]     rsp_pm_value,
   output logic [9:0]            rsp_am_value,
   output logic                  rsp_last,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cmd_type cmd;

   fmlfo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   fmlfo_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_opcode       (req_opcode),
      .req_noise_index  (req_noise_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_channel      (rsp_channel),
      .rsp_pm_value     (rsp_pm_value),
      .rsp_am_value     (rsp_am_value),
      .rsp_last         (rsp_last)
   );

endmodule
